### rtl/sodhb_pkg.sv
// Package for the send-on-delta heartbeat filter: sizes, field types and codes.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sodhb_pkg;

    localparam int CHANNELS    = 16;
    localparam int CHAN_W      = 4;
    localparam int CHAN_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_CMP_W  = CHAN_W + 1;
    localparam int VALUE_W     = 32;
    localparam int CFG_W       = 16;
    localparam int KIND_BITS   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] DEADBAND_RESET  = 16'd1311;
    localparam logic [CFG_W-1:0] HEARTBEAT_RESET = 16'd1000;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_SCALAR = 2'd0,
        KIND_FLAG   = 2'd1,
        KIND_PAIR   = 2'd2,
        KIND_OTHER  = 2'd3
    } kind_t;

    typedef enum logic {
        REG_DEADBAND  = 1'b0,
        REG_HEARTBEAT = 1'b1
    } reg_index_t;

    typedef enum logic {
        WHY_CHANGED   = 1'b0,
        WHY_HEARTBEAT = 1'b1
    } why_t;

    typedef struct packed {
        logic               cmd;
        logic [CHAN_W-1:0]  channel;
        logic [1:0]         kind;
        logic signed [31:0] scalar_value;
        logic               flag_value;
        logic signed [7:0]  state_id;
        logic signed [15:0] maneuver_id;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_channel;
        logic               why_sent;
        logic [1:0]         out_kind;
        logic signed [31:0] out_scalar;
        logic               out_flag;
        logic signed [7:0]  out_state;
        logic signed [15:0] out_maneuver;
    } out_item_t;

    // Classified request passed from front to back.
    typedef struct packed {
        logic                   is_tick;
        logic                   chan_ok;
        logic [CHAN_W-1:0]      channel;
        kind_t                  kind;
        logic [KIND_BITS-1:0]   kind_bit;
        logic [VALUE_W-1:0]     scalar;
        logic                   flag;
        logic [23:0]            pair;
    } req_t;

    typedef struct packed {
        logic [CFG_W-1:0] deadband;
        logic [CFG_W-1:0] heartbeat_ms;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/send_on_delta_heartbeat_filter.sv
// Top level of the send-on-delta heartbeat filter: configuration registers and
// the front, queue and back parts. Depends on sodhb_pkg and the sodhb_* modules.
//
// Usage: each request on the item channel (item_valid / item_stall / item) is
// either a one-millisecond tick or a sample on a channel. A sample is forwarded
// on the result channel (result_valid / result_stall / result) when it changed
// beyond the deadband, is the first of its kind on the channel, or the channel
// has been silent longer than heartbeat_ms. Ticks and filtered samples give no
// result. The write port (cfg_we / cfg_index / cfg_data) sets the deadband and
// the heartbeat period; write it only while the block is idle.
// A result is offered once its sample has passed a queue entry and then the
// result register, and stays offered until the receiver takes it.
// Throughput: one request per cycle while the result is not stalled, set by the
// channel state update in the back part.
// Reset clears the time counter, every channel's send time and seen marks, the
// queue and the result valid flag, and loads the default configuration.
// When the receiver stalls, the result holds, the back part stops, and the
// two-entry queue fills; item_stall rises once it is full.
`default_nettype none

module send_on_delta_heartbeat_filter
    import sodhb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire in_item_t         item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output out_item_t             result,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic q_push;
    req_t q_req;
    logic q_pop;
    logic head_valid;
    req_t head_req;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_DEADBAND:  cfg_next.deadband     = cfg_data;
                REG_HEARTBEAT: cfg_next.heartbeat_ms = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband     <= DEADBAND_RESET;
            cfg_reg.heartbeat_ms <= HEARTBEAT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sodhb_front u_front (
        .item_valid (item_valid),
        .item       (item),
        .q_full     (q_full),
        .item_stall (item_stall),
        .q_push     (q_push),
        .q_req      (q_req)
    );

    sodhb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_req   (q_req),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_req   (head_req)
    );

    sodhb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_req     (head_req),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### rtl/sodhb_front.sv
// Front part: accepts input requests and classifies them for the back part.
// Depends on sodhb_pkg.
`default_nettype none

module sodhb_front
    import sodhb_pkg::*;
(
    input  wire logic     item_valid,
    input  wire in_item_t item,
    input  wire logic     q_full,
    output logic          item_stall,
    output logic          q_push,
    output req_t          q_req
);

    kind_t kind;

    assign kind       = kind_t'(item.kind);
    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;

    always_comb
    begin
        q_req          = '0;
        q_req.is_tick  = (item.cmd == CMD_TICK);
        q_req.chan_ok  = ({1'b0, item.channel} < CHAN_CMP_W'(CHANNELS));
        q_req.channel  = item.channel;
        q_req.kind     = kind;
        unique case (kind)
            KIND_SCALAR:
            begin
                q_req.kind_bit = 3'b001;
                q_req.scalar   = item.scalar_value;
            end
            KIND_FLAG:
            begin
                q_req.kind_bit = 3'b010;
                q_req.flag     = item.flag_value;
            end
            KIND_PAIR:
            begin
                q_req.kind_bit = 3'b100;
                q_req.pair     = {item.state_id, item.maneuver_id};
            end
            default:
            begin
                q_req.kind_bit = 3'b000;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/sodhb_queue.sv
// Short request queue between front and back parts.
// Depends on sodhb_pkg.
`default_nettype none

module sodhb_queue
    import sodhb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire req_t push_req,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output req_t      head_req
);

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_req   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

### rtl/sodhb_back.sv
// Back part: per-channel change and heartbeat decision, channel state, result register.
// Depends on sodhb_pkg.
`default_nettype none

module sodhb_back
    import sodhb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      head_valid,
    input  wire req_t      head_req,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result
);

    logic [VALUE_W-1:0]    now_reg, now_next;
    logic [VALUE_W-1:0]    last_sent_reg [CHANNELS];
    logic [KIND_BITS-1:0]  seen_reg      [CHANNELS];
    logic [VALUE_W-1:0]    held_scalar_reg [CHANNELS];
    logic                  held_flag_reg   [CHANNELS];
    logic [23:0]           held_pair_reg   [CHANNELS];
    logic                  result_valid_reg, result_valid_next;
    out_item_t             result_reg;

    logic [CHAN_IDX_W-1:0] idx;
    logic                  out_free;
    logic                  sample;
    logic                  first;
    logic signed [32:0]    diff;
    logic [32:0]           abs_diff;
    logic                  changed;
    logic                  beat;
    logic                  send;
    logic [VALUE_W-1:0]    elapsed;

    assign idx          = head_req.channel[CHAN_IDX_W-1:0];
    assign out_free     = !result_valid_reg || !result_stall;
    assign pop          = head_valid && out_free;
    assign sample       = pop && !head_req.is_tick && head_req.chan_ok;
    assign first        = ((seen_reg[idx] & head_req.kind_bit) == '0);
    assign diff         = {held_scalar_reg[idx][31], held_scalar_reg[idx]}
                        - {head_req.scalar[31], head_req.scalar};
    assign abs_diff     = diff[32] ? 33'(-diff) : 33'(diff);
    assign elapsed      = now_reg - last_sent_reg[idx];
    assign beat         = (elapsed > {16'b0, cfg.heartbeat_ms});
    assign send         = changed || beat;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        unique case (head_req.kind)
            KIND_SCALAR: changed = first || (abs_diff > {17'b0, cfg.deadband});
            KIND_FLAG:   changed = first || (held_flag_reg[idx] != head_req.flag);
            KIND_PAIR:   changed = first || (held_pair_reg[idx] != head_req.pair);
            default:     changed = 1'b0;
        endcase
    end

    always_comb
    begin
        now_next          = now_reg;
        result_valid_next = result_valid_reg;
        if (pop && head_req.is_tick)
        begin
            now_next = now_reg + 1'b1;
        end
        if (out_free)
        begin
            result_valid_next = sample && send;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg          <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_sent_reg[i] <= '0;
                seen_reg[i]      <= '0;
            end
        end
        else
        begin
            now_reg          <= now_next;
            result_valid_reg <= result_valid_next;
            if (sample && changed)
            begin
                seen_reg[idx] <= seen_reg[idx] | head_req.kind_bit;
            end
            if (sample && send)
            begin
                last_sent_reg[idx] <= now_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample && changed)
        begin
            unique case (head_req.kind)
                KIND_SCALAR: held_scalar_reg[idx] <= head_req.scalar;
                KIND_FLAG:   held_flag_reg[idx]   <= head_req.flag;
                KIND_PAIR:   held_pair_reg[idx]   <= head_req.pair;
                default:     ;
            endcase
        end
        if (sample && send)
        begin
            result_reg.out_channel  <= head_req.channel;
            result_reg.why_sent     <= changed ? WHY_CHANGED : WHY_HEARTBEAT;
            result_reg.out_kind     <= head_req.kind;
            result_reg.out_scalar   <= head_req.scalar;
            result_reg.out_flag     <= head_req.flag;
            result_reg.out_state    <= head_req.pair[23:16];
            result_reg.out_maneuver <= head_req.pair[15:0];
        end
    end

endmodule

`default_nettype wire
